// ===== rtl/tscu_pkg.sv =====
// Shared types, constants and coefficient table for the sine, cosine and tangent unit.
// Used by tscu_fmul, tscu_div and taylor_sin_cos_tan_unit; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tscu_pkg;

  // Fraction bits of the angle and of the result.
  localparam int FRAC_BITS = 24;

  // Width of the quarter-turn quotient of the largest angle magnitude.
  localparam int Q_BITS    = 32 - FRAC_BITS;
  // Shift that turns (magnitude * TWO_OVER_PI_Q) into the quotient estimate.
  localparam int Q_SHIFT   = 32 + FRAC_BITS;
  // Shift from the input format up to the internal Q2.61 format.
  localparam int RED_SHIFT = 61 - FRAC_BITS;
  localparam int RED_W     = 32 + RED_SHIFT;
  localparam int QH_W      = Q_BITS + 64;
  // Width of a sine or cosine magnitude after rounding to the output format.
  localparam int RND_W     = FRAC_BITS + 3;

  // Tangent division: integer and fraction quotient bits, spread over stages.
  localparam int DIV_BITS      = (Q_BITS + 1) + (FRAC_BITS + 1);
  localparam int DIV_PER_STAGE = 7;
  localparam int DIV_STAGES    = (DIV_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
  localparam int LIM_W         = 64 + Q_BITS;

  // Polynomial: highest coefficient index for long and short series.
  localparam int LONG_TOP     = 7;
  localparam int SHORT_TOP    = 2;
  localparam int HORNER_STEPS = LONG_TOP + 3;

  localparam logic [63:0] HALF_PI_Q61   = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q61       = 64'h2000000000000000;
  // Slightly below 2^93 / HALF_PI_Q61 so that the quotient estimate never overshoots.
  localparam logic [31:0] TWO_OVER_PI_Q = 32'd2734261090;

  localparam logic [1:0] CMD_SIN = 2'd0;
  localparam logic [1:0] CMD_COS = 2'd1;
  localparam logic [1:0] CMD_TAN = 2'd2;

  typedef logic signed [63:0] q61_t;

  // Odd Taylor coefficients (-1)^k / (2k+1)! for k = 1 .. 8 in Q2.61.
  localparam q61_t COEF [0:LONG_TOP] = '{
    -64'sd384307168202282325, 64'sd19215358410114116, -64'sd457508533574146,
    64'sd6354285188530, -64'sd57766228987, 64'sd370296340, -64'sd1763316,
    64'sd6483
  };

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_SC,
    KIND_TAN
  } kind_e;

  // Control and operands that travel with an item through the polynomial stages.
  typedef struct packed {
    logic       valid;
    logic [1:0] cmd;
    logic       neg;
    logic [1:0] quad;
    logic       short_terms;
    logic       zero;
    q61_t [1:0] x;
    q61_t [1:0] s;
  } pside_t;

  // Control that travels with an item through the divider.
  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic             neg;
    logic [RND_W-1:0] mag_sc;
  } dside_t;

endpackage

`default_nettype wire

// ===== rtl/tscu_fmul.sv =====
// Two-lane pipelined Q2.61 multiply-add, four register stages per product.
// Depends on tscu_pkg for the operand type and the side-band struct.
`timescale 1ns / 1ps
`default_nettype none

module tscu_fmul
  import tscu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  q61_t [1:0] a_i,
  input  q61_t [1:0] b_i,
  input  q61_t [1:0] c_i,
  input  pside_t     side_i,
  output q61_t [1:0] p_o,
  output pside_t     side_o
);

  pside_t side1_q, side2_q, side3_q, side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q <= '0;
      side2_q <= '0;
      side3_q <= '0;
      side4_q <= '0;
    end else if (en_i) begin
      side1_q <= side_i;
      side2_q <= side1_q;
      side3_q <= side2_q;
      side4_q <= side3_q;
    end
  end

  assign side_o = side4_q;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic        neg1_q, neg2_q, neg3_q;
    logic [63:0] ua1_q, ub1_q;
    q61_t        c1_q, c2_q, c3_q, p4_q;
    logic [63:0] pll2_q, plh2_q, phl2_q, phh2_q;
    logic [63:0] pm3_q;
    logic        rb3_q;
    logic [127:0] full;

    assign full = {64'b0, pll2_q} + {32'b0, plh2_q, 32'b0} + {32'b0, phl2_q, 32'b0}
                + {phh2_q, 64'b0};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg1_q <= a_i[l][63] ^ b_i[l][63];
        ua1_q  <= a_i[l][63] ? 64'(-a_i[l]) : a_i[l];
        ub1_q  <= b_i[l][63] ? 64'(-b_i[l]) : b_i[l];
        c1_q   <= c_i[l];

        neg2_q <= neg1_q;
        c2_q   <= c1_q;
        pll2_q <= ua1_q[31:0] * ub1_q[31:0];
        plh2_q <= ua1_q[31:0] * ub1_q[63:32];
        phl2_q <= ua1_q[63:32] * ub1_q[31:0];
        phh2_q <= ua1_q[63:32] * ub1_q[63:32];

        neg3_q <= neg2_q;
        c3_q   <= c2_q;
        pm3_q  <= full[124:61];
        rb3_q  <= full[60];

        // Round half away from zero, apply the sign and add in one adder.
        p4_q   <= c3_q + (neg3_q ? ~pm3_q : pm3_q) + {63'b0, neg3_q ^ rb3_q};
      end
    end

    assign p_o[l] = p4_q;
  end

endmodule

`default_nettype wire

// ===== rtl/tscu_div.sv =====
// Pipelined restoring divider for the tangent, with a range check on the quotient.
// Depends on tscu_pkg for widths and the side-band struct.
`timescale 1ns / 1ps
`default_nettype none

module tscu_div
  import tscu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [63:0]         num_i,
  input  logic [63:0]         den_i,
  input  dside_t              side_i,
  output logic [DIV_BITS-1:0] quo_o,
  output logic                sat_o,
  output dside_t              side_o
);

  logic [63:0]    num0_q, den0_q;
  logic [LIM_W-1:0] lim0_q;
  dside_t         sd0_q;

  logic [63:0]         rem_q [DIV_STAGES+1];
  logic [DIV_BITS-1:0] quo_q [DIV_STAGES+1];
  logic [63:0]         num_q [DIV_STAGES+1];
  logic [63:0]         den_q [DIV_STAGES+1];
  logic                sat_q [DIV_STAGES+1];
  dside_t              sd_q  [DIV_STAGES+1];

  // The range check flags num >= (2^Q_BITS + 1) * den, or a zero divisor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd0_q   <= '0;
      sd_q[0] <= '0;
    end else if (en_i) begin
      sd0_q   <= side_i;
      sd_q[0] <= sd0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num0_q   <= num_i;
      den0_q   <= den_i;
      lim0_q   <= (LIM_W'(den_i) << Q_BITS) + LIM_W'(den_i);
      num_q[0] <= num0_q;
      den_q[0] <= den0_q;
      sat_q[0] <= (den0_q == 64'd0) || (LIM_W'(num0_q) >= lim0_q);
      rem_q[0] <= num0_q >> (Q_BITS + 1);
      quo_q[0] <= '0;
    end
  end

  for (genvar st = 0; st < DIV_STAGES; st++) begin : g_stage
    logic [63:0]             rem;
    logic [DIV_BITS-1:0]     quo;
    logic [64+FRAC_BITS:0]   nwide;

    always_comb begin
      int k;
      rem   = rem_q[st];
      quo   = quo_q[st];
      nwide = {num_q[st], {(FRAC_BITS + 1){1'b0}}};
      for (int j = 0; j < DIV_PER_STAGE; j++) begin
        k = DIV_BITS - 1 - (st * DIV_PER_STAGE + j);
        if (k >= 0) begin
          rem = {rem[62:0], nwide[k]};
          if (rem >= den_q[st]) begin
            rem    = rem - den_q[st];
            quo[k] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sd_q[st+1] <= '0;
      end else if (en_i) begin
        sd_q[st+1] <= sd_q[st];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[st+1] <= rem;
        quo_q[st+1] <= quo;
        num_q[st+1] <= num_q[st];
        den_q[st+1] <= den_q[st];
        sat_q[st+1] <= sat_q[st];
      end
    end
  end

  assign quo_o  = quo_q[DIV_STAGES];
  assign sat_o  = sat_q[DIV_STAGES];
  assign side_o = sd_q[DIV_STAGES];

endmodule

`default_nettype wire

// ===== rtl/taylor_sin_cos_tan_unit.sv =====
// Taylor-series sine, cosine and tangent unit, top level.
// Depends on tscu_pkg, tscu_fmul (polynomial stages) and tscu_div (tangent divider).
//
// The unit takes one angle per clock in signed Q7.24 radians together with a command
// (sine, cosine or tangent) and a series-length flag, and returns one Q7.24 result per
// angle with a saturation flag, in order. It is a fixed pipeline of 56 register stages:
// six stages reduce the magnitude of the angle modulo a quarter turn (a 32x32 multiply
// by 2/pi gives the quotient, a narrow multiply and one correction give the remainder
// and quadrant), ten multiply-add steps of four stages each evaluate the odd sine
// polynomial in Horner form for the remainder and for its complement in parallel, one
// stage applies the quadrant rules, seven stages check the range of the tangent quotient and
// form it, and two stages round and saturate into the output register. A new transfer is
// taken every cycle while the output register is empty or being read; when the result
// in the output register is not taken, the whole pipeline holds and nothing is lost.
// The short series runs to x^7 and the long one to x^17; both take the same latency.
// Cosine of zero is exactly one, a zero tangent divisor saturates with the flag set,
// and the unused command code returns zero with the flag clear.
`timescale 1ns / 1ps
`default_nettype none

module taylor_sin_cos_tan_unit
  import tscu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // angle [31:0]
  input  logic [2:0]  s_tuser_i,   // command [1:0], short_series [2]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,   // value [31:0]
  output logic [0:0]  m_tuser_o    // saturated [0]
);

  // The whole pipeline moves together; it stops only while a result waits.
  logic adv;
  logic out_v_q;

  assign adv        = !out_v_q || m_tready_i;
  assign s_tready_o = adv;

  // Range reduction stages.
  logic              r1_v_q, r2_v_q, r3_v_q, r4_v_q, r5_v_q;
  logic [1:0]        r1_cmd_q, r2_cmd_q, r3_cmd_q, r4_cmd_q, r5_cmd_q;
  logic              r1_sht_q, r2_sht_q, r3_sht_q, r4_sht_q, r5_sht_q;
  logic [31:0]       r1_ang_q;
  logic              r2_neg_q, r3_neg_q, r4_neg_q, r5_neg_q;
  logic [31:0]       r2_mag_q, r3_mag_q, r4_mag_q;
  logic              r3_zero_q, r4_zero_q, r5_zero_q;
  logic [63:0]       r3_prod_q;
  logic [Q_BITS-1:0] r4_qe_q, r5_qe_q;
  logic [QH_W-1:0]   r4_qh_q;
  logic [63:0]       r5_r0_q;
  pside_t            red_q;

  logic [Q_BITS-1:0] qe_d;
  logic [RED_W-1:0]  xbig;
  logic              ge;

  assign qe_d = r3_prod_q[Q_SHIFT +: Q_BITS];
  assign xbig = {r4_mag_q, {RED_SHIFT{1'b0}}};
  assign ge   = r5_r0_q >= HALF_PI_Q61;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q <= 1'b0;
      r2_v_q <= 1'b0;
      r3_v_q <= 1'b0;
      r4_v_q <= 1'b0;
      r5_v_q <= 1'b0;
      red_q  <= '0;
    end else if (adv) begin
      r1_v_q <= s_tvalid_i;
      r2_v_q <= r1_v_q;
      r3_v_q <= r2_v_q;
      r4_v_q <= r3_v_q;
      r5_v_q <= r4_v_q;
      red_q.valid       <= r5_v_q;
      red_q.cmd         <= r5_cmd_q;
      red_q.neg         <= r5_neg_q;
      red_q.short_terms <= r5_sht_q;
      red_q.zero        <= r5_zero_q;
      red_q.quad        <= 2'(r5_qe_q + Q_BITS'(ge));
      // The sine lane sees the remainder, the cosine lane its complement.
      red_q.x[0]        <= ge ? 64'(r5_r0_q - HALF_PI_Q61) : r5_r0_q;
      red_q.x[1]        <= ge ? 64'({HALF_PI_Q61, 1'b0} - {1'b0, r5_r0_q})
                              : 64'(HALF_PI_Q61 - r5_r0_q);
      red_q.s           <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1_cmd_q  <= s_tuser_i[1:0];
      r1_sht_q  <= s_tuser_i[2];
      r1_ang_q  <= s_tdata_i;

      r2_cmd_q  <= r1_cmd_q;
      r2_sht_q  <= r1_sht_q;
      r2_neg_q  <= r1_ang_q[31];
      r2_mag_q  <= r1_ang_q[31] ? 32'(-r1_ang_q) : r1_ang_q;

      r3_cmd_q  <= r2_cmd_q;
      r3_sht_q  <= r2_sht_q;
      r3_neg_q  <= r2_neg_q;
      r3_mag_q  <= r2_mag_q;
      r3_zero_q <= r2_mag_q == 32'd0;
      r3_prod_q <= r2_mag_q * TWO_OVER_PI_Q;

      r4_cmd_q  <= r3_cmd_q;
      r4_sht_q  <= r3_sht_q;
      r4_neg_q  <= r3_neg_q;
      r4_mag_q  <= r3_mag_q;
      r4_zero_q <= r3_zero_q;
      r4_qe_q   <= qe_d;
      r4_qh_q   <= QH_W'(qe_d) * QH_W'(HALF_PI_Q61);

      r5_cmd_q  <= r4_cmd_q;
      r5_sht_q  <= r4_sht_q;
      r5_neg_q  <= r4_neg_q;
      r5_zero_q <= r4_zero_q;
      r5_qe_q   <= r4_qe_q;
      // The estimate is exact or one low, so this remainder is below twice a quarter turn.
      r5_r0_q   <= 64'(QH_W'(xbig) - r4_qh_q);
    end
  end

  // Horner steps: first x*x, then the coefficient chain, then 1 + s*acc, then x*acc.
  pside_t     hs_in  [HORNER_STEPS];
  pside_t     hs_out [HORNER_STEPS];
  q61_t [1:0] ha [HORNER_STEPS];
  q61_t [1:0] hb [HORNER_STEPS];
  q61_t [1:0] hc [HORNER_STEPS];
  q61_t [1:0] hp [HORNER_STEPS];

  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_step
    if (j == 0) begin : g_square
      always_comb begin
        hs_in[j] = red_q;
        ha[j]    = red_q.x;
        hb[j]    = red_q.x;
        hc[j]    = '0;
      end
    end else begin : g_chain
      localparam int CK = (j <= LONG_TOP) ? LONG_TOP - j : 0;
      always_comb begin
        hs_in[j] = hs_out[j-1];
        if (j == 1) begin
          hs_in[j].s = hp[0];
        end
        for (int l = 0; l < 2; l++) begin
          if (j == HORNER_STEPS - 1) begin
            ha[j][l] = hs_in[j].x[l];
          end else begin
            ha[j][l] = hs_in[j].s[l];
          end
          if (j == 1) begin
            hb[j][l] = COEF[LONG_TOP];
          end else if (j == LONG_TOP - SHORT_TOP + 1 && hs_in[j].short_terms) begin
            // The short series starts its chain here.
            hb[j][l] = COEF[SHORT_TOP];
          end else begin
            hb[j][l] = hp[j-1][l];
          end
          if (j <= LONG_TOP) begin
            hc[j][l] = COEF[CK];
          end else if (j == LONG_TOP + 1) begin
            hc[j][l] = ONE_Q61;
          end else begin
            hc[j][l] = '0;
          end
        end
      end
    end

    tscu_fmul u_fmul (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .a_i    (ha[j]),
      .b_i    (hb[j]),
      .c_i    (hc[j]),
      .side_i (hs_in[j]),
      .p_o    (hp[j]),
      .side_o (hs_out[j])
    );
  end

  // Quadrant rules: pick the lane, the sign and, for tangent, numerator and divisor.
  pside_t      ps;
  logic [63:0] sp, cp;
  kind_e       kind_d;
  logic        neg_d;
  logic [63:0] num_d, den_d;

  assign ps = hs_out[HORNER_STEPS-1];
  assign sp = hp[HORNER_STEPS-1][0][63] ? 64'd0 : hp[HORNER_STEPS-1][0];
  assign cp = hp[HORNER_STEPS-1][1][63] ? 64'd0 : hp[HORNER_STEPS-1][1];

  always_comb begin
    kind_d = KIND_NONE;
    neg_d  = 1'b0;
    num_d  = 64'd0;
    den_d  = 64'd0;
    case (ps.cmd)
      CMD_SIN: begin
        kind_d = KIND_SC;
        num_d  = ps.quad[0] ? cp : sp;
        neg_d  = (ps.quad[1] != ps.neg) && (num_d != 64'd0);
      end
      CMD_COS: begin
        kind_d = KIND_SC;
        if (ps.quad == 2'd0) begin
          num_d = ps.zero ? ONE_Q61 : cp;
        end else begin
          num_d = ps.quad[0] ? sp : cp;
        end
        neg_d = (ps.quad == 2'd1 || ps.quad == 2'd2) && (num_d != 64'd0);
      end
      CMD_TAN: begin
        kind_d = KIND_TAN;
        if (ps.quad[0]) begin
          neg_d = !ps.neg;
          num_d = cp;
          den_d = sp;
        end else begin
          neg_d = ps.neg && (sp != 64'd0);
          num_d = sp;
          den_d = cp;
        end
      end
      default: begin
        kind_d = KIND_NONE;
      end
    endcase
  end

  logic        p1_v_q;
  kind_e       p1_kind_q;
  logic        p1_neg_q;
  logic [63:0] p1_num_q, p1_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (adv) begin
      p1_v_q <= ps.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_kind_q <= kind_d;
      p1_neg_q  <= neg_d;
      p1_num_q  <= num_d;
      p1_den_q  <= den_d;
    end
  end

  // Sine and cosine are rounded here and ride through the divider unchanged.
  dside_t              dv_in, dv_out;
  logic [DIV_BITS-1:0] dv_quo;
  logic                dv_sat;
  logic [63:0]         rnd_sum;

  assign rnd_sum = p1_num_q + (64'd1 << (RED_SHIFT - 1));

  always_comb begin
    dv_in.valid  = p1_v_q;
    dv_in.kind   = p1_kind_q;
    dv_in.neg    = p1_neg_q;
    dv_in.mag_sc = RND_W'(rnd_sum >> RED_SHIFT);
  end

  tscu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .num_i  (p1_num_q),
    .den_i  (p1_den_q),
    .side_i (dv_in),
    .quo_o  (dv_quo),
    .sat_o  (dv_sat),
    .side_o (dv_out)
  );

  // Magnitude select, then clip to the signed 32-bit range.
  logic                e1_v_q, e1_neg_q, e1_flag_q;
  logic [DIV_BITS-1:0] e1_mag_q;
  logic [DIV_BITS-1:0] mag_d;
  logic                flag_d;
  logic [DIV_BITS:0]   qr;
  logic [DIV_BITS-1:0] lim;
  logic                over;
  logic [31:0]         val_q;
  logic                sat_q;

  assign qr = {1'b0, dv_quo} + (DIV_BITS + 1)'(1);

  always_comb begin
    mag_d  = '0;
    flag_d = 1'b0;
    case (dv_out.kind)
      KIND_TAN: begin
        if (dv_sat) begin
          mag_d  = '1;
          flag_d = 1'b1;
        end else begin
          mag_d = qr[DIV_BITS:1];
        end
      end
      KIND_SC: begin
        mag_d = DIV_BITS'(dv_out.mag_sc);
      end
      default: begin
        mag_d = '0;
      end
    endcase
  end

  assign lim  = e1_neg_q ? (DIV_BITS'(1) << 31) : ((DIV_BITS'(1) << 31) - DIV_BITS'(1));
  assign over = e1_mag_q > lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      e1_v_q  <= dv_out.valid;
      out_v_q <= e1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_neg_q  <= dv_out.neg;
      e1_flag_q <= flag_d;
      e1_mag_q  <= mag_d;
      if (over) begin
        val_q <= e1_neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        val_q <= e1_neg_q ? 32'(-e1_mag_q[31:0]) : e1_mag_q[31:0];
      end
      sat_q <= e1_flag_q || over;
    end
  end

  assign m_tvalid_o   = out_v_q;
  assign m_tdata_o    = val_q;
  assign m_tuser_o[0] = sat_q;

  // An empty output register must never hold back the input side.
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid_o |-> s_tready_o)
    else $error("input stalled while output register is empty");

  // A saturated result is always one of the two range limits.
  a_sat_at_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o[0]) |->
      (m_tdata_o == 32'h7FFF_FFFF || m_tdata_o == 32'h8000_0000))
    else $error("saturated flag with a value inside the range");

  // After the correction step the remainder lies below a quarter turn.
  a_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_q.valid |-> ($unsigned(red_q.x[0]) < HALF_PI_Q61))
    else $error("range reduction left a remainder of a quarter turn or more");

  // While the output waits, no new transfer may enter.
  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |-> !s_tready_o)
    else $error("input accepted while the pipeline is stalled");

endmodule

`default_nettype wire
